FILE: hw/rtl/tail_delimited_float_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef TAIL_DELIMITED_FLOAT_DEFRAMER_CORE_MACROS_SVH
`define TAIL_DELIMITED_FLOAT_DEFRAMER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock of the enclosing module.
`define DTFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer check failed");
// Check that a condition is followed by an outcome on the next clock.
`define DTFD_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("deframer sequence check failed");
`else
`define DTFD_ASSERT(lbl, prop)
`define DTFD_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

FILE: hw/rtl/dtfd_pkg.sv
// Types and constants shared by the deframer modules.
package dtfd_pkg;

    localparam logic [1:0]  ERR_NONE     = 2'd0;
    localparam logic [1:0]  ERR_LENGTH   = 2'd1;
    localparam logic [1:0]  ERR_OVERFLOW = 2'd2;

    localparam logic [31:0] TAIL_RESET   = 32'h7F80_0000;
    localparam logic [11:0] COUNT_MAX    = 12'hFFF;
    localparam logic [2:0]  FILL_FULL    = 3'd4;

    // value 32 + index 4 + count 5 + frame 32 + error 2 + length 12, padded to bytes
    localparam int          OUT_W        = 88;

    // One closed frame, handed from the front to the back.
    typedef struct packed {
        logic [1:0]  err;
        logic [11:0] payload_bytes;
        logic [4:0]  channel_count;
        logic [31:0] frame_number;
        logic        bank;
    } desc_t;

    // Back end hands a store bank back to the front.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

FILE: hw/rtl/dtfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/dtfd_desc_fifo.sv
// Two-entry queue of closed-frame descriptors between front and back.
module dtfd_desc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dtfd_pkg::desc_t push_desc,
    input  logic            pop,
    output dtfd_pkg::desc_t head_desc,
    output logic            full,
    output logic            empty
);
    import dtfd_pkg::*;

    desc_t      entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign head_desc = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

FILE: hw/rtl/dtfd_front.sv
// Byte intake: tail window, payload packing into the store, frame close.
module dtfd_front #(
    parameter int STORE_WORDS = 16,
    localparam int IW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output logic            q_push,
    output dtfd_pkg::desc_t q_desc,
    input  logic            q_full,
    input  dtfd_pkg::rel_t  rel,
    output logic            wr_en,
    output logic [IW:0]     wr_addr,
    output logic [31:0]     wr_data
);
    import dtfd_pkg::*;

    `include "tail_delimited_float_deframer_core_macros.svh"

    localparam logic [11:0] THR = 12'(4 * STORE_WORDS);

    logic [31:0] tail_reg;
    logic [31:0] window_reg;
    logic [31:0] window_next;
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic [11:0] count_reg;
    logic [11:0] count_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic [31:0] gfc_reg;
    logic        bank_reg;
    logic [1:0]  busy_reg;
    logic [1:0]  busy_next;

    logic        accept;
    logic        take;
    logic        room;
    logic [7:0]  pl;
    logic        close;
    logic        good;
    logic [IW-1:0] widx;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full && !busy_reg[bank_reg];
    assign take     = (fill_reg == FILL_FULL);
    assign room     = (count_reg < THR);
    assign pl       = window_reg[7:0];
    assign widx     = count_reg[IW+1:2];

    assign wr_en    = accept && take && room && (count_reg[1:0] == 2'd3);
    assign wr_addr  = {bank_reg, widx};
    assign wr_data  = {pl, partial_reg};

    always_comb
    begin
        window_next  = {in_byte, window_reg[31:8]};
        fill_next    = take ? FILL_FULL : fill_reg + 3'd1;
        partial_next = partial_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        if (take)
        begin
            if (room)
            begin
                case (count_reg[1:0])
                    2'd0:    partial_next = {16'd0, pl};
                    2'd1:    partial_next = {8'd0, pl, partial_reg[7:0]};
                    2'd2:    partial_next = {pl, partial_reg[15:0]};
                    default: partial_next = partial_reg;
                endcase
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 12'd1;
            end
        end
    end

    assign close = accept && (fill_next == FILL_FULL) && (window_next == tail_reg);

    // Classify the closing frame from the counts after this beat
    always_comb
    begin
        q_desc               = '0;
        q_desc.payload_bytes = count_next;
        good                 = 1'b0;
        if (ovf_next)
        begin
            q_desc.err = ERR_OVERFLOW;
        end
        else if (count_next == 12'd0 || count_next[1:0] != 2'd0)
        begin
            q_desc.err = ERR_LENGTH;
        end
        else
        begin
            good                 = 1'b1;
            q_desc.err           = ERR_NONE;
            q_desc.channel_count = count_next[6:2];
            q_desc.frame_number  = gfc_reg + 32'd1;
            q_desc.bank          = bank_reg;
        end
    end

    assign q_push = close;

    always_comb
    begin
        busy_next = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (close && good)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg    <= TAIL_RESET;
            window_reg  <= 32'd0;
            fill_reg    <= 3'd0;
            partial_reg <= 24'd0;
            count_reg   <= 12'd0;
            ovf_reg     <= 1'b0;
            gfc_reg     <= 32'd0;
            bank_reg    <= 1'b0;
            busy_reg    <= 2'b00;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_we)
            begin
                tail_reg <= cfg_wdata;
            end
            if (close)
            begin
                // restart the window and payload for the next frame
                window_reg  <= 32'd0;
                fill_reg    <= 3'd0;
                partial_reg <= 24'd0;
                count_reg   <= 12'd0;
                ovf_reg     <= 1'b0;
                if (good)
                begin
                    gfc_reg  <= gfc_reg + 32'd1;
                    bank_reg <= !bank_reg;
                end
            end
            else if (accept)
            begin
                window_reg  <= window_next;
                fill_reg    <= fill_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    `DTFD_ASSERT(a_fill_max, fill_reg <= FILL_FULL)
    `DTFD_ASSERT(a_ovf_matches_count, ovf_reg == (count_reg > THR))

endmodule

FILE: hw/rtl/dtfd_back.sv
// Result sequencer: reads stored words per closed frame and drives result beats.
module dtfd_back #(
    parameter int STORE_WORDS = 16,
    localparam int IW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  dtfd_pkg::desc_t          q_desc,
    output logic                     q_pop,
    output logic                     rd_en,
    output logic [IW:0]              rd_addr,
    input  logic [31:0]              rd_data,
    output dtfd_pkg::rel_t           rel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [dtfd_pkg::OUT_W-1:0] out_data,
    output logic                     out_last
);
    import dtfd_pkg::*;

    `include "tail_delimited_float_deframer_core_macros.svh"

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_HOLD = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    desc_t            desc_reg;
    logic [IW-1:0]    idx_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic             word_last;

    assign word_last = ((5'(idx_reg) + 5'd1) == desc_reg.channel_count);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {desc_reg.bank, idx_reg + IW'(1)};
        case (state_reg)
            B_IDLE:
            begin
                rd_addr = {q_desc.bank, {IW{1'b0}}};
                rd_en   = !q_empty && (q_desc.err == ERR_NONE);
            end
            B_HOLD:
            begin
                rd_en = out_ready && !out_last_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_desc.err == ERR_NONE) ? B_READ : B_HOLD;
                end
            end
            B_READ:
            begin
                state_next = B_HOLD;
            end
            B_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = out_last_reg ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hand the bank back as its final word is loaded from the store into the output register
    assign rel.valid = (state_reg == B_READ) && word_last;
    assign rel.bank  = desc_reg.bank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:
                begin
                    out_valid_reg <= !q_empty && (q_desc.err != ERR_NONE);
                end
                B_READ:
                begin
                    out_valid_reg <= 1'b1;
                end
                B_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    desc_reg <= q_desc;
                    idx_reg  <= {IW{1'b0}};
                    // error beat: value, index, count and frame all zero
                    out_data_reg <= {1'b0, q_desc.payload_bytes, q_desc.err,
                                     32'd0, 5'd0, 4'd0, 32'd0};
                    out_last_reg <= 1'b1;
                end
            end
            B_READ:
            begin
                out_data_reg <= {1'b0, desc_reg.payload_bytes, desc_reg.err,
                                 desc_reg.frame_number, desc_reg.channel_count,
                                 4'(idx_reg), rd_data};
                out_last_reg <= word_last;
            end
            B_HOLD:
            begin
                if (out_ready && !out_last_reg)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    `DTFD_ASSERT(a_error_is_last, (out_valid_reg && out_data_reg[74:73] != ERR_NONE) |-> out_last_reg)
    `DTFD_ASSERT_NEXT(a_read_loads_beat, state_reg == B_READ, state_reg == B_HOLD && out_valid_reg)

endmodule

FILE: hw/rtl/tail_delimited_float_deframer_core.sv
// Top level of the tail-delimited float frame deframer.
//
//  channel   dir  payload                                         handshake
//  s_axis    in   s_tdata[7:0] rx_byte                            s_tvalid/s_tready
//  m_axis    out  m_tdata value/index/count/frame/error/length    m_tvalid/m_tready
//                 m_tlast last
//  cfg       in   cfg_data[31:0] tail_word                        cfg_valid/cfg_ready
//
// Input takes one byte per cycle; it stalls only when the descriptor queue is
// full or the store bank for the next frame is still being read out.
// Each good result is a registered store read, then a load of the output
// register; an error result is loaded into it straight from its descriptor.
// Reset clears all control state; the word store needs no clearing pass.
// A stalled output holds its beat while the front keeps taking bytes.
module tail_delimited_float_deframer_core #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] value_bits, [35:32] channel_index, [40:36] channel_count,
    // [72:41] frame_number, [74:73] error_code, [86:75] payload_bytes, [87] zero
    output logic [dtfd_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [31:0]                cfg_data
);
    import dtfd_pkg::*;

    localparam int STORE_WORDS = (MAX_CHANNELS > 16) ? 16 :
                                 ((MAX_CHANNELS < 1) ? 1 : MAX_CHANNELS);
    localparam int IW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    desc_t       push_desc;
    desc_t       head_desc;
    rel_t        rel;
    logic        wr_en;
    logic [IW:0] wr_addr;
    logic [31:0] wr_data;
    logic        rd_en;
    logic [IW:0] rd_addr;
    logic [31:0] rd_data;

    assign cfg_ready = 1'b1;

    dtfd_front #(
        .STORE_WORDS(STORE_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_wdata(cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .q_push   (q_push),
        .q_desc   (push_desc),
        .q_full   (q_full),
        .rel      (rel),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    dtfd_desc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_desc(push_desc),
        .pop      (q_pop),
        .head_desc(head_desc),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Two banks of the word store: one fills while the other drains
    dtfd_ram #(
        .WIDTH(32),
        .DEPTH(2 << IW)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    dtfd_back #(
        .STORE_WORDS(STORE_WORDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_desc   (head_desc),
        .q_pop    (q_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rel      (rel),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the tail-delimited float frame deframer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfd_pkg::*;

    localparam int CHANNELS       = 16;
    localparam int STORE_WORDS    = (CHANNELS > 16) ? 16 : CHANNELS;
    localparam int STORE_BYTES    = 4 * STORE_WORDS;
    localparam int SETTLE_CYCLES  = 64;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 16;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic [4:0]  count;
        logic [31:0] frame;
        logic [1:0]  err;
        logic [11:0] len;
        logic        is_last;
    } chan_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [31:0]      cfg_data  = 32'h0;

    // Predicted deframer state
    logic [31:0] tail_pat;
    logic [31:0] win_bytes;
    logic [2:0]  win_count;
    logic [31:0] word_mem [STORE_WORDS];
    logic [23:0] part_word;
    logic [11:0] pay_len;
    logic        overflowed;
    logic [31:0] good_frames;

    chan_result_t expected_results[$];

    int errors          = 0;
    int results_checked = 0;
    int bytes_sent      = 0;
    int err_frames      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_cycles     = 0;

    tail_delimited_float_deframer_core #(
        .MAX_CHANNELS(CHANNELS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the predicted deframer by one received byte and queue its results.
    function automatic void deframe_byte(input logic [7:0] b);
        chan_result_t r;
        int nwords;
        if (win_count == FILL_FULL)
        begin
            // oldest window byte drops out as payload
            if (pay_len >= STORE_BYTES)
            begin
                overflowed = 1'b1;
            end
            else
            begin
                case (pay_len[1:0])
                    2'd0:    part_word = {16'h0, win_bytes[7:0]};
                    2'd1:    part_word[15:8] = win_bytes[7:0];
                    2'd2:    part_word[23:16] = win_bytes[7:0];
                    default: word_mem[pay_len[5:2]] = {win_bytes[7:0], part_word};
                endcase
            end
            if (pay_len != COUNT_MAX)
                pay_len++;
        end
        else
        begin
            win_count++;
        end
        win_bytes = {b, win_bytes[31:8]};
        if (win_count != FILL_FULL || win_bytes != tail_pat)
            return;

        r = '0;
        r.len = pay_len;
        r.is_last = 1'b1;
        if (overflowed)
        begin
            r.err = ERR_OVERFLOW;
            expected_results.push_back(r);
            err_frames++;
        end
        else if (pay_len == 12'd0 || pay_len[1:0] != 2'd0)
        begin
            r.err = ERR_LENGTH;
            expected_results.push_back(r);
            err_frames++;
        end
        else
        begin
            nwords = int'(pay_len[11:2]);
            good_frames++;
            for (int i = 0; i < nwords; i++)
            begin
                r.value   = word_mem[i];
                r.index   = 4'(i);
                r.count   = 5'(nwords);
                r.frame   = good_frames;
                r.err     = ERR_NONE;
                r.is_last = (i == nwords - 1);
                expected_results.push_back(r);
            end
        end
        win_bytes  = '0;
        win_count  = '0;
        part_word  = '0;
        pay_len    = '0;
        overflowed = 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_tail();
        for (int j = 0; j < 4; j++)
            send_byte(tail_pat[8*j +: 8]);
    endtask

    task automatic send_frame(input int n_payload);
        for (int i = 0; i < n_payload; i++)
            send_byte(8'($urandom_range(255)));
        send_tail();
    endtask

    // Hold the input until every queued result is out, then let the core settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tail(input logic [31:0] pat);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= pat;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        tail_pat = pat;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t tb: mismatch %s expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Default tail: empty frame, extreme words, bad length, tail look-alikes,
    // full store and overflow.
    task automatic test_default_tail();
        send_tail();
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        send_tail();
        send_frame(5);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h80); send_byte(8'h7E);
        send_byte(8'h5A); send_byte(8'h00); send_byte(8'h00); send_byte(8'h80);
        send_tail();
        send_frame(STORE_BYTES);
        send_frame(STORE_BYTES + 1);
    endtask

    task automatic test_tail_config();
        logic [31:0] pats [3];
        pats[0] = 32'h0000_0000;
        pats[1] = 32'hFFFF_FFFF;
        pats[2] = $urandom;
        foreach (pats[k])
        begin
            write_tail(pats[k]);
            send_tail();
            send_frame(4);
            send_frame(8);
            send_frame(3);
        end
        write_tail(TAIL_RESET);
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise.
    task automatic run_random(input int n_bytes);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_frame(4 * (($urandom_range(9) == 0) ? STORE_WORDS : $urandom_range(1, 4)));
            else if (pick < 88)
                send_frame(($urandom_range(4) == 0) ? 0
                           : 4 * $urandom_range(0, 3) + $urandom_range(1, 3));
            else if (pick < 94)
                send_frame($urandom_range(STORE_BYTES + 1, STORE_BYTES + 8));
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(PHASE_BYTES);
        write_tail($urandom);
        send_idle_pct = 75; recv_stall_pct = 0;
        run_random(PHASE_BYTES);
        write_tail(32'hFFFF_FFFF);
        send_idle_pct = 0;  recv_stall_pct = 75;
        run_random(PHASE_BYTES);
        write_tail(TAIL_RESET);
        send_idle_pct = 32; recv_stall_pct = 32;
        run_random(PHASE_BYTES);
    endtask

    // Block the output for a long stretch while full frames keep arriving.
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = HOLD_OFF;
        repeat (3) send_frame(STORE_BYTES);
    endtask

    initial
    begin : output_ready
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Sample between edges: a beat seen here is taken at the next rising edge.
    initial
    begin : result_check
        chan_result_t want;
        forever
        begin
            @(negedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t tb: unexpected beat expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("value_bits", want.value, m_tdata[31:0]);
                    check_field("channel_index", 32'(want.index), 32'(m_tdata[35:32]));
                    check_field("channel_count", 32'(want.count), 32'(m_tdata[40:36]));
                    check_field("frame_number", want.frame, m_tdata[72:41]);
                    check_field("error_code", 32'(want.err), 32'(m_tdata[74:73]));
                    check_field("payload_bytes", 32'(want.len), 32'(m_tdata[86:75]));
                    check_field("pad_bit", 32'h0, 32'(m_tdata[87]));
                    check_field("last", 32'(want.is_last), 32'(m_tlast));
                    results_checked++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t tb: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin : main
        tail_pat    = TAIL_RESET;
        win_bytes   = '0;
        win_count   = '0;
        part_word   = '0;
        pay_len     = '0;
        overflowed  = 1'b0;
        good_frames = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_tail();
        test_tail_config();
        test_random_phases();
        test_backpressure();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: covered %0d bytes, %0d results checked, %0d good and %0d error frames",
                 bytes_sent, results_checked, good_frames, err_frames);
        $display("tb: tails default/zero/all-ones/random, idle and stall mixes, long hold-off");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dtfd_pkg.sv
hw/rtl/dtfd_ram.sv
hw/rtl/dtfd_desc_fifo.sv
hw/rtl/dtfd_front.sv
hw/rtl/dtfd_back.sv
hw/rtl/tail_delimited_float_deframer_core.sv
sim/tb.sv
